// ===== rtl/intensity_remap_gaussian_noise_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the intensity remap and Gaussian noise block.
// Each macro checks a property on the rising edge of clk, off during reset.
// ----------------------------------------------------------------------------
`ifndef INTENSITY_REMAP_GAUSSIAN_NOISE_MACROS_SVH
`define INTENSITY_REMAP_GAUSSIAN_NOISE_MACROS_SVH

// The consequence must hold in the same cycle as the condition.
`define IRGN_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequence must hold in the cycle after the condition.
`define IRGN_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/irgn_pkg.sv =====
// ----------------------------------------------------------------------------
// irgn_pkg
// Shared widths, constants, register codes and the logarithm function.
// ----------------------------------------------------------------------------
package irgn_pkg;

	// Fraction bits of the Q.30 values and number of log squaring steps.
	localparam int FRAC      = 30;
	localparam int LOG_CELLS = 30;

	// Width of a log2 result in Q.30 (up to 32.0).
	localparam int LG_W = 36;
	// Width of -2 ln u1 in Q.30.
	localparam int W_W  = 37;
	// Radicand width of the square root and the number of its steps.
	localparam int SQ_W     = 40;
	localparam int SQ_CELLS = SQ_W / 2;
	localparam int R_W      = 20;

	// 2 ln 2 in Q.28.
	localparam logic [28:0] TWO_LN2_Q28 = 29'd372130559;

	// Taylor coefficients of sin(pi/2 x) in Q.30.
	localparam logic [30:0] SIN_C1 = 31'd1686629713;
	localparam logic [30:0] SIN_C3 = 31'd693598668;
	localparam logic [30:0] SIN_C5 = 31'd85569306;
	localparam logic [30:0] SIN_C7 = 31'd5026995;
	localparam logic [30:0] SIN_C9 = 31'd172272;

	// Register indexes of the configuration port.
	typedef enum logic [2:0] {
		REG_THRESHOLD  = 3'd0,
		REG_GAIN       = 3'd1,
		REG_OUT_MIN    = 3'd2,
		REG_BACKGROUND = 3'd3,
		REG_NOISE_MEAN = 3'd4,
		REG_NOISE_SDEV = 3'd5
	} reg_idx_t;

	// Truncated log2 in Q.30 by repeated squaring; evaluated on constants only.
	function automatic logic [LG_W-1:0] log2_q30(input logic [31:0] x);
		logic [63:0]     m;
		logic [LG_W-1:0] res;
		int              e;
		e = 0;
		for (int i = 1; i < 32; i++) begin
			if ((x >> i) != 32'd0) e = i;
		end
		m   = {32'd0, x} << (31 - e);
		res = LG_W'(e) << FRAC;
		for (int i = 1; i <= FRAC; i++) begin
			m = (m * m) >> 31;
			if (m >= (64'd1 << 32)) begin
				m   = m >> 1;
				res = res | (LG_W'(1) << (FRAC - i));
			end
		end
		if (x == 32'd0) res = '0;
		return res;
	endfunction

endpackage

// ===== rtl/intensity_remap_gaussian_noise.sv =====
// Throughput: one voxel per cycle unless the output stalls; the log squaring and square root
// cell chains and the sine multiplier stages all advance together with the output register.
// A stalled output freezes the whole pipeline, holding every item in place.
// Reset clears all pipeline valid bits and loads the register defaults (gain 1.0).
// ----------------------------------------------------------------------------
// intensity_remap_gaussian_noise
// Thresholded linear remap of voxel intensities plus Box-Muller noise, Q16.16.
// ----------------------------------------------------------------------------
`include "intensity_remap_gaussian_noise_macros.svh"

module intensity_remap_gaussian_noise import irgn_pkg::*; #(
	parameter int UNIFORM_BITS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	// Fields from bit 0: voxel[31:0], uniform_a, uniform_b, zero fill.
	input  logic [((32+2*UNIFORM_BITS+7)/8)*8-1:0] s_axis_tdata,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// Fields from bit 0: noisy_voxel[31:0].
	output logic [31:0] m_axis_tdata,
	// Fields from bit 0: saturated.
	output logic [0:0]  m_axis_tuser,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [4:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	localparam logic [31:0]     DMAX     = 32'((64'd1 << UNIFORM_BITS) - 64'd1);
	localparam logic [LG_W-1:0] LOG_DMAX = log2_q30(DMAX);
	localparam logic [LG_W-1:0] LOG_ZERO = LG_W'(UNIFORM_BITS) << FRAC;
	localparam int REP        = 32 / UNIFORM_BITS + 1;
	localparam int ST_LG      = 1 + LOG_CELLS + 1;
	localparam int ST_W       = ST_LG + 1;
	localparam int ST_SQ_END  = ST_W + SQ_CELLS;
	localparam int ST_G       = ST_SQ_END + 1;
	localparam int ST_N       = ST_G + 1;
	localparam int DEPTH      = ST_N + 1;
	localparam int SINE_OUT   = 1 + 7;
	localparam int BASE_W     = 51;

	// Configuration registers.
	logic signed [31:0] threshold_q, gain_q, out_min_q, background_q, noise_mean_q;
	logic [30:0]        noise_sdev_q;
	logic               cfg_wr;
	reg_idx_t           cfg_idx;

	assign pready  = 1'b1;
	assign cfg_wr  = psel & penable & pwrite & pready;
	assign cfg_idx = reg_idx_t'(paddr[4:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			threshold_q  <= '0;
			gain_q       <= 32'sd65536;
			out_min_q    <= '0;
			background_q <= '0;
			noise_mean_q <= '0;
			noise_sdev_q <= '0;
		end else if (cfg_wr) begin
			unique case (cfg_idx)
				REG_THRESHOLD:  threshold_q  <= pwdata;
				REG_GAIN:       gain_q       <= pwdata;
				REG_OUT_MIN:    out_min_q    <= pwdata;
				REG_BACKGROUND: background_q <= pwdata;
				REG_NOISE_MEAN: noise_mean_q <= pwdata;
				REG_NOISE_SDEV: noise_sdev_q <= pwdata[30:0];
				default: ;
			endcase
		end
	end

	// Register read back.
	always_comb begin
		unique case (cfg_idx)
			REG_THRESHOLD:  prdata = threshold_q;
			REG_GAIN:       prdata = gain_q;
			REG_OUT_MIN:    prdata = out_min_q;
			REG_BACKGROUND: prdata = background_q;
			REG_NOISE_MEAN: prdata = noise_mean_q;
			REG_NOISE_SDEV: prdata = {1'b0, noise_sdev_q};
			default:        prdata = '0;
		endcase
	end

	// Pipeline advance and valid bits.
	logic [DEPTH:1] vld_q;
	logic           en;

	assign en            = !vld_q[DEPTH] || m_axis_tready;
	assign s_axis_tready = en;
	assign m_axis_tvalid = vld_q[DEPTH];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[DEPTH-1:1], s_axis_tvalid};
		end
	end

	// Input fields.
	logic signed [31:0]       voxel;
	logic [UNIFORM_BITS-1:0]  ua, ub;
	assign voxel = s_axis_tdata[31:0];
	assign ua    = s_axis_tdata[32 +: UNIFORM_BITS];
	assign ub    = s_axis_tdata[32+UNIFORM_BITS +: UNIFORM_BITS];

	// Log2 normalization: leading one position and left-aligned mantissa.
	logic [31:0] a32, m_c;
	logic [4:0]  e_c;
	assign a32 = 32'(ua);
	always_comb begin
		e_c = '0;
		for (int i = 1; i < 32; i++) begin
			if (a32[i]) e_c = 5'(i);
		end
	end
	assign m_c = a32 << (5'd31 - e_c);

	// Phase in turns: the uniform value repeated as a binary fraction.
	logic [REP*UNIFORM_BITS-1:0] rep_c;
	logic [31:0]                 phase_c;
	assign rep_c   = {REP{ub}};
	assign phase_c = (ub == UNIFORM_BITS'(DMAX)) ? 32'd0
	                                             : rep_c[REP*UNIFORM_BITS-1 -: 32];

	// Remap product of gain and distance above threshold.
	logic signed [32:0] diff_c;
	logic signed [64:0] prod_c;
	assign diff_c = 33'(voxel) - 33'(threshold_q);
	assign prod_c = gain_q * diff_c;

	logic [31:0]        m_s1, phase_s1;
	logic [LG_W-1:0]    res_s1;
	logic               zero_s1, le_s1;
	logic signed [64:0] prod_s1;

	always_ff @(posedge clk) begin
		if (en) begin
			m_s1     <= m_c;
			res_s1   <= LG_W'({e_c, {FRAC{1'b0}}});
			zero_s1  <= (ua == '0);
			phase_s1 <= phase_c;
			prod_s1  <= prod_c;
			le_s1    <= (voxel <= threshold_q);
		end
	end

	// Base value: background or floored remap plus the output minimum.
	logic signed [BASE_W-1:0] base_s2, base_d;
	logic signed [48:0]       shifted_c;
	assign shifted_c = prod_s1[64:16];

	always_ff @(posedge clk) begin
		if (en) begin
			if (le_s1) base_s2 <= BASE_W'(background_q);
			else base_s2 <= BASE_W'(shifted_c) + BASE_W'(out_min_q);
		end
	end

	irgn_delay #(.WIDTH(BASE_W), .DEPTH(ST_N - 2)) u_base_dly (
		.clk (clk), .en (en), .din (base_s2), .dout (base_d)
	);

	// Log squaring cell chain.
	logic [31:0]     lm   [LOG_CELLS+1];
	logic [LG_W-1:0] lres [LOG_CELLS+1];
	logic            lz   [LOG_CELLS+1];
	assign lm[0]   = m_s1;
	assign lres[0] = res_s1;
	assign lz[0]   = zero_s1;

	for (genvar i = 0; i < LOG_CELLS; i++) begin : g_log
		irgn_log_cell #(.BIT_POS(LOG_CELLS - 1 - i)) u_cell (
			.clk (clk), .en (en),
			.m_i (lm[i]), .res_i (lres[i]), .zero_i (lz[i]),
			.m_o (lm[i+1]), .res_o (lres[i+1]), .zero_o (lz[i+1])
		);
	end

	// -log2(u1), then -2 ln u1 in Q.30.
	logic [LG_W-1:0] lg_s32;
	logic [W_W-1:0]  w_s33;
	logic [64:0]     wp_c;
	assign wp_c = 65'(lg_s32) * 65'(TWO_LN2_Q28);

	always_ff @(posedge clk) begin
		if (en) begin
			if (lz[LOG_CELLS]) lg_s32 <= LOG_ZERO;
			else if (LOG_DMAX > lres[LOG_CELLS]) lg_s32 <= LOG_DMAX - lres[LOG_CELLS];
			else lg_s32 <= '0;
			w_s33 <= wp_c[28 +: W_W];
		end
	end

	// Square root cell chain for the radius.
	logic [SQ_W-1:0] sn [SQ_CELLS+1];
	logic [SQ_W-1:0] sr [SQ_CELLS+1];
	assign sn[0] = SQ_W'({w_s33, 2'b00});
	assign sr[0] = '0;

	for (genvar i = 0; i < SQ_CELLS; i++) begin : g_sqrt
		irgn_sqrt_cell #(.K(SQ_CELLS - 1 - i)) u_cell (
			.clk (clk), .en (en),
			.n_i (sn[i]), .res_i (sr[i]),
			.n_o (sn[i+1]), .res_o (sr[i+1])
		);
	end

	// Sine of the angle, delayed to meet the radius.
	logic [30:0] mag_c, mag_d;
	logic        neg_c, neg_d;

	irgn_sine u_sine (
		.clk (clk), .en (en), .phase (phase_s1), .mag (mag_c), .neg (neg_c)
	);

	irgn_delay #(.WIDTH(32), .DEPTH(ST_SQ_END - SINE_OUT)) u_sine_dly (
		.clk (clk), .en (en), .din ({neg_c, mag_c}), .dout ({neg_d, mag_d})
	);

	// Noise magnitude, sign and the saturating sum.
	logic [50:0]        gp_c;
	logic [34:0]        g_s54;
	logic               neg_s54;
	logic [65:0]        np_c;
	logic signed [36:0] noise_s55;
	logic signed [52:0] total_c;

	assign gp_c    = 51'(sr[SQ_CELLS][R_W-1:0]) * 51'(mag_d);
	assign np_c    = 66'(g_s54) * 66'(noise_sdev_q);
	assign total_c = 53'(base_d) + 53'(noise_s55) + 53'(noise_mean_q);

	always_ff @(posedge clk) begin
		if (en) begin
			g_s54   <= gp_c[50:16];
			neg_s54 <= neg_d;
			if (neg_s54) noise_s55 <= -$signed({1'b0, np_c[65:30]});
			else noise_s55 <= $signed({1'b0, np_c[65:30]});
			if (total_c > 53'sd2147483647) begin
				m_axis_tdata <= 32'h7fffffff;
				m_axis_tuser <= 1'b1;
			end else if (total_c < -53'sd2147483648) begin
				m_axis_tdata <= 32'h80000000;
				m_axis_tuser <= 1'b1;
			end else begin
				m_axis_tdata <= total_c[31:0];
				m_axis_tuser <= 1'b0;
			end
		end
	end

	// Checks on the pipeline control and the saturation flag.
	`IRGN_ASSERT_NEXT(a_accept_enters, s_axis_tvalid && s_axis_tready, vld_q[1], "accepted item missing in first stage")
	`IRGN_ASSERT_NEXT(a_stall_holds, !en, vld_q == $past(vld_q), "pipeline moved during a stall")
	`IRGN_ASSERT_NOW(a_sat_value, m_axis_tvalid && m_axis_tuser[0], (m_axis_tdata == 32'h7fffffff) || (m_axis_tdata == 32'h80000000), "saturated flag without a clipped value")

endmodule

// ===== rtl/irgn_delay.sv =====
// ----------------------------------------------------------------------------
// irgn_delay
// Shift line that carries side data along the pipeline while it advances.
// ----------------------------------------------------------------------------
module irgn_delay #(
	parameter int WIDTH = 1,
	parameter int DEPTH = 1
) (
	input  logic             clk,
	input  logic             en,
	input  logic [WIDTH-1:0] din,
	output logic [WIDTH-1:0] dout
);

	logic [WIDTH-1:0] line_q [DEPTH];

	// Every tap moves one place whenever the pipeline advances.
	always_ff @(posedge clk) begin
		if (en) begin
			line_q[0] <= din;
			for (int i = 1; i < DEPTH; i++) begin
				line_q[i] <= line_q[i-1];
			end
		end
	end

	assign dout = line_q[DEPTH-1];

endmodule

// ===== rtl/irgn_log_cell.sv =====
// ----------------------------------------------------------------------------
// irgn_log_cell
// One squaring step of the log2 mantissa, resolving one fraction bit.
// ----------------------------------------------------------------------------
module irgn_log_cell import irgn_pkg::*; #(
	parameter int BIT_POS = 29
) (
	input  logic            clk,
	input  logic            en,
	input  logic [31:0]     m_i,
	input  logic [LG_W-1:0] res_i,
	input  logic            zero_i,
	output logic [31:0]     m_o,
	output logic [LG_W-1:0] res_o,
	output logic            zero_o
);

	logic [63:0] prod;
	logic [32:0] sq;

	// Square the Q1.31 mantissa; a value of two or more gives a one bit.
	assign prod = 64'(m_i) * 64'(m_i);
	assign sq   = prod[63:31];

	always_ff @(posedge clk) begin
		if (en) begin
			zero_o <= zero_i;
			if (sq[32]) begin
				m_o   <= sq[32:1];
				res_o <= res_i | (LG_W'(1) << BIT_POS);
			end else begin
				m_o   <= sq[31:0];
				res_o <= res_i;
			end
		end
	end

endmodule

// ===== rtl/irgn_sqrt_cell.sv =====
// ----------------------------------------------------------------------------
// irgn_sqrt_cell
// One restoring step of the integer square root, for one result bit.
// ----------------------------------------------------------------------------
module irgn_sqrt_cell import irgn_pkg::*; #(
	parameter int K = 0
) (
	input  logic            clk,
	input  logic            en,
	input  logic [SQ_W-1:0] n_i,
	input  logic [SQ_W-1:0] res_i,
	output logic [SQ_W-1:0] n_o,
	output logic [SQ_W-1:0] res_o
);

	localparam logic [SQ_W:0] BIT = (SQ_W+1)'(1) << (2 * K);

	logic [SQ_W:0] trial;

	assign trial = {1'b0, res_i} + BIT;

	// Subtract the trial value when it fits and shift the root estimate.
	always_ff @(posedge clk) begin
		if (en) begin
			if ({1'b0, n_i} >= trial) begin
				n_o   <= SQ_W'({1'b0, n_i} - trial);
				res_o <= SQ_W'({2'b0, res_i[SQ_W-1:1]} + BIT);
			end else begin
				n_o   <= n_i;
				res_o <= {1'b0, res_i[SQ_W-1:1]};
			end
		end
	end

endmodule

// ===== rtl/irgn_sine.sv =====
// ----------------------------------------------------------------------------
// irgn_sine
// Pipelined sine of a Q0.32 phase: quarter-wave folding and a Taylor series.
// ----------------------------------------------------------------------------
module irgn_sine import irgn_pkg::*; (
	input  logic        clk,
	input  logic        en,
	input  logic [31:0] phase,
	output logic [30:0] mag,
	output logic        neg
);

	// One Horner step: c - x2 * t, truncated to Q.30.
	function automatic logic [30:0] horner(input logic [30:0] c,
		input logic [30:0] x2, input logic [30:0] t);
		logic [61:0] p;
		p = 62'(x2) * 62'(t);
		return 31'(c - 31'(p >> FRAC));
	endfunction

	logic [30:0] x_s1, x_s2, x_s3, x_s4, x_s5, x_s6;
	logic [30:0] x2_s2, x2_s3, x2_s4, x2_s5;
	logic [30:0] t_s3, t_s4, t_s5, t_s6;
	logic        neg_s1, neg_s2, neg_s3, neg_s4, neg_s5, neg_s6;
	logic [61:0] sq_c;
	logic [61:0] fin_c;

	assign sq_c  = 62'(x_s1) * 62'(x_s1);
	assign fin_c = 62'(x_s6) * 62'(t_s6);

	always_ff @(posedge clk) begin
		if (en) begin
			// Fold odd quarters back onto the first one.
			x_s1   <= phase[30] ? 31'((32'd1 << FRAC) - {2'b0, phase[29:0]})
			                    : {1'b0, phase[29:0]};
			neg_s1 <= phase[31];
			// Square of the folded angle.
			x_s2   <= x_s1;
			x2_s2  <= 31'(sq_c >> FRAC);
			neg_s2 <= neg_s1;
			// Horner steps from the ninth power down.
			x_s3   <= x_s2;
			x2_s3  <= x2_s2;
			t_s3   <= horner(SIN_C7, x2_s2, SIN_C9);
			neg_s3 <= neg_s2;
			x_s4   <= x_s3;
			x2_s4  <= x2_s3;
			t_s4   <= horner(SIN_C5, x2_s3, t_s3);
			neg_s4 <= neg_s3;
			x_s5   <= x_s4;
			x2_s5  <= x2_s4;
			t_s5   <= horner(SIN_C3, x2_s4, t_s4);
			neg_s5 <= neg_s4;
			x_s6   <= x_s5;
			t_s6   <= horner(SIN_C1, x2_s5, t_s5);
			neg_s6 <= neg_s5;
			// Final product with the angle, clamped at one.
			if (fin_c[61:FRAC] > 32'(32'd1 << FRAC)) mag <= 31'(32'd1 << FRAC);
			else mag <= fin_c[60:FRAC];
			neg <= neg_s6;
		end
	end

endmodule
